@@ rtl/psr_pkg.sv @@
// ----------------------------------------------------------------------------
// psr_pkg
// Shared widths, codes, state type and control structs of the peak search
// with parabolic refinement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psr_pkg;

  localparam int SampleBits = 16;
  localparam int IndexBits  = 10;
  localparam int CountBits  = 11;
  localparam int FracBits   = 8;
  localparam int PosBits    = 18;
  localparam int KindBits   = 2;
  localparam int CfgIdxBits = 2;
  localparam int CfgBits    = 10;

  localparam logic [CountBits-1:0] CountMax = '1;

  localparam logic [CfgIdxBits-1:0] REG_WINDOW_START = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_WINDOW_STOP  = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_PEAK_KIND    = 2'd2;

  localparam logic [KindBits-1:0] KIND_GLOBAL = 2'd0;
  localparam logic [KindBits-1:0] KIND_SECOND = 2'd2;

  localparam logic [IndexBits-1:0] WindowStartReset = '0;
  localparam logic [IndexBits-1:0] WindowStopReset  = '1;
  localparam logic [KindBits-1:0]  PeakKindReset    = KIND_GLOBAL;

  // divider: 18 quotient bits, one per cycle
  localparam int DenBits  = 17;
  localparam int DiffBits = SampleBits + 1;
  localparam int DivBits  = DenBits + 2;
  localparam int StepBits = $clog2(PosBits);
  localparam logic [StepBits-1:0] LastStep = StepBits'(PosBits - 1);

  typedef enum logic [2:0] {
    ST_RUN,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_LOAD
  } psr_state_t;

  typedef struct packed {
    logic sample_en;
    logic prep;
    logic mul_load;
    logic div_step;
    logic out_load;
  } psr_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_full;
  } psr_stat_t;

endpackage

@@ rtl/psr_if.sv @@
// ----------------------------------------------------------------------------
// psr_in_if / psr_out_if
// Valid/ready channels for samples and peak results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [psr_pkg::SampleBits-1:0] sample;
  logic                                 frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface psr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 found;
  logic        [psr_pkg::IndexBits-1:0]  peak_index;
  logic signed [psr_pkg::SampleBits-1:0] peak_value;
  logic        [psr_pkg::PosBits-1:0]    refined_position;
  logic signed [psr_pkg::SampleBits-1:0] refined_value;

  modport source (output valid, output found, output peak_index, output peak_value,
                  output refined_position, output refined_value, input ready);
  modport sink   (input valid, input found, input peak_index, input peak_value,
                  input refined_position, input refined_value, output ready);
endinterface

@@ rtl/psr_ctrl.sv @@
// ----------------------------------------------------------------------------
// psr_ctrl
// Frame sequencer: streams samples, then runs prep, multiply, divide and
// result load steps of the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_frame_end,
  output logic               in_ready,
  input  logic               out_ready,
  input  psr_pkg::psr_stat_t stat,
  output psr_pkg::psr_cmd_t  cmd
);

  psr_pkg::psr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psr_pkg::ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      psr_pkg::ST_RUN: begin
        in_ready      = 1'b1;
        cmd.sample_en = in_valid;
        if (in_valid && in_frame_end) begin
          state_nxt = psr_pkg::ST_PREP;
        end
      end
      psr_pkg::ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = psr_pkg::ST_MUL;
      end
      psr_pkg::ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = psr_pkg::ST_DIV;
      end
      psr_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = psr_pkg::ST_LOAD;
        end
      end
      psr_pkg::ST_LOAD: begin
        if (!stat.out_full || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = psr_pkg::ST_RUN;
        end
      end
      default: begin
        state_nxt = psr_pkg::ST_RUN;
      end
    endcase
  end

endmodule

@@ rtl/psr_datapath.sv @@
// ----------------------------------------------------------------------------
// psr_datapath
// Config registers, running peak trackers, refinement arithmetic, restoring
// divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psr_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic        [psr_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic        [psr_pkg::CfgBits-1:0]    cfg_data,
  input  logic signed [psr_pkg::SampleBits-1:0] in_sample,
  input  logic                                  in_frame_end,
  input  psr_pkg::psr_cmd_t                     cmd,
  output psr_pkg::psr_stat_t                    stat,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  out_found,
  output logic        [psr_pkg::IndexBits-1:0]  out_peak_index,
  output logic signed [psr_pkg::SampleBits-1:0] out_peak_value,
  output logic        [psr_pkg::PosBits-1:0]    out_refined_position,
  output logic signed [psr_pkg::SampleBits-1:0] out_refined_value
);

  localparam int SB = psr_pkg::SampleBits;
  localparam int IB = psr_pkg::IndexBits;
  localparam int CB = psr_pkg::CountBits;
  localparam int PB = psr_pkg::PosBits;
  localparam int DB = psr_pkg::DenBits;
  localparam int FB = psr_pkg::DiffBits;
  localparam int VB = psr_pkg::DivBits;
  localparam int MB = IB + DB + 1;          // idx * dd
  localparam int TB = MB + 3;               // idx * dd + (c - a), signed
  localparam int NB = TB + psr_pkg::FracBits + 1;
  localparam int WB = SB + 3;               // 2b - a - c and a + 2b + c

  // configuration
  logic [IB-1:0]                 ws_r, wst_r;
  logic [psr_pkg::KindBits-1:0]  kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r   <= psr_pkg::WindowStartReset;
      wst_r  <= psr_pkg::WindowStopReset;
      kind_r <= psr_pkg::PeakKindReset;
    end else if (cfg_we) begin
      case (cfg_index)
        psr_pkg::REG_WINDOW_START: ws_r   <= cfg_data[IB-1:0];
        psr_pkg::REG_WINDOW_STOP:  wst_r  <= cfg_data[IB-1:0];
        psr_pkg::REG_PEAK_KIND:    kind_r <= cfg_data[psr_pkg::KindBits-1:0];
        default: ;
      endcase
    end
  end

  // frame trackers
  logic [CB-1:0]        cnt_r;
  logic signed [SB-1:0] prev_r, prev2_r;
  logic signed [SB-1:0] best_v_r, best_l_r, best_rt_r;
  logic [IB-1:0]        best_i_r;
  logic [1:0]           hits_r;
  logic [IB-1:0]        hit_i_r;
  logic signed [SB-1:0] hit_l_r, hit_c_r, hit_rt_r;

  logic [CB-1:0]        ctr, ws_x, wst_x;
  logic                 has_ctr, upd_g, upd_l, cap;
  logic signed [SB-1:0] bv_nxt, bl_nxt, br_nxt, hl_nxt, hc_nxt, hr_nxt;
  logic [IB-1:0]        bi_nxt, hi_nxt;
  logic [1:0]           hits_nxt;
  logic [CB:0]          n_len;
  logic                 ok_g, ok_l;

  always_comb begin
    ctr     = cnt_r - CB'(1);
    ws_x    = CB'(ws_r);
    wst_x   = CB'(wst_r);
    has_ctr = cnt_r != '0;
    upd_g   = has_ctr && ctr >= ws_x && ctr <= wst_x &&
              (ctr == ws_x || prev_r > best_v_r);
    bv_nxt  = upd_g ? prev_r    : best_v_r;
    bl_nxt  = upd_g ? prev2_r   : best_l_r;
    br_nxt  = upd_g ? in_sample : best_rt_r;
    bi_nxt  = upd_g ? ctr[IB-1:0] : best_i_r;
    upd_l   = has_ctr && ctr > ws_x && ctr < wst_x && prev2_r < prev_r &&
              in_sample < prev_r && hits_r < 2'd2;
    hits_nxt = upd_l ? hits_r + 2'd1 : hits_r;
    cap      = upd_l && hits_nxt == kind_r;
    hi_nxt   = cap ? ctr[IB-1:0] : hit_i_r;
    hl_nxt   = cap ? prev2_r     : hit_l_r;
    hc_nxt   = cap ? prev_r      : hit_c_r;
    hr_nxt   = cap ? in_sample   : hit_rt_r;
    n_len    = {1'b0, cnt_r} + (CB+1)'(1);
    ok_g = ((CB+1)'(wst_r) < n_len) && (ws_r < wst_r) &&
           !(wst_x == cnt_r && in_sample > bv_nxt) &&
           !(bi_nxt == ws_r || bi_nxt == wst_r);
    ok_l = (kind_r <= psr_pkg::KIND_SECOND) &&
           ((CB+1)'(wst_r) + (CB+1)'(1) < n_len) && (hits_nxt >= kind_r);
  end

  // captured peak of the finished frame
  logic                 pk_ok_r;
  logic [IB-1:0]        pk_i_r;
  logic signed [SB-1:0] pk_a_r, pk_b_r, pk_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      prev_r    <= '0;
      prev2_r   <= '0;
      best_v_r  <= '0;
      best_l_r  <= '0;
      best_rt_r <= '0;
      best_i_r  <= '0;
      hits_r    <= '0;
      hit_i_r   <= '0;
      hit_l_r   <= '0;
      hit_c_r   <= '0;
      hit_rt_r  <= '0;
    end else if (cmd.sample_en) begin
      if (in_frame_end) begin
        cnt_r     <= '0;
        prev_r    <= '0;
        prev2_r   <= '0;
        best_v_r  <= '0;
        best_l_r  <= '0;
        best_rt_r <= '0;
        best_i_r  <= '0;
        hits_r    <= '0;
        hit_i_r   <= '0;
        hit_l_r   <= '0;
        hit_c_r   <= '0;
        hit_rt_r  <= '0;
      end else begin
        if (cnt_r != psr_pkg::CountMax) begin
          cnt_r <= cnt_r + CB'(1);
        end
        prev2_r   <= prev_r;
        prev_r    <= in_sample;
        best_v_r  <= bv_nxt;
        best_l_r  <= bl_nxt;
        best_rt_r <= br_nxt;
        best_i_r  <= bi_nxt;
        hits_r    <= hits_nxt;
        hit_i_r   <= hi_nxt;
        hit_l_r   <= hl_nxt;
        hit_c_r   <= hc_nxt;
        hit_rt_r  <= hr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_en && in_frame_end) begin
      if (kind_r == psr_pkg::KIND_GLOBAL) begin
        pk_ok_r <= ok_g;
        pk_i_r  <= bi_nxt;
        pk_a_r  <= bl_nxt;
        pk_b_r  <= bv_nxt;
        pk_c_r  <= br_nxt;
      end else begin
        pk_ok_r <= ok_l;
        pk_i_r  <= hi_nxt;
        pk_a_r  <= hl_nxt;
        pk_b_r  <= hc_nxt;
        pk_c_r  <= hr_nxt;
      end
    end
  end

  // refinement: pos = (2*num + dd) / (4*den), num = 2^F * (idx*dd + c - a)
  logic signed [WB-1:0] den_w, sum_w;
  logic [DB-1:0]        den_r;
  logic signed [FB-1:0] diff_r;
  logic [DB:0]          dd;
  logic [MB-1:0]        prod;
  logic [TB-1:0]        t_w;
  logic [NB-1:0]        n_w;
  logic [VB-1:0]        rem_r, d_r;
  logic [PB-1:0]        q_r;
  logic [VB:0]          trial;
  logic                 ge;
  logic [psr_pkg::StepBits-1:0] step_r;

  always_comb begin
    den_w = (WB'(pk_b_r) <<< 1) - WB'(pk_a_r) - WB'(pk_c_r);
    sum_w = WB'(pk_a_r) + (WB'(pk_b_r) <<< 1) + WB'(pk_c_r) + WB'(2);
    dd    = {den_r, 1'b0};
    prod  = MB'(pk_i_r) * MB'(dd);
    t_w   = TB'(prod) + TB'(diff_r);
    n_w   = {t_w, {(psr_pkg::FracBits + 1){1'b0}}} + NB'(dd);
    trial = {rem_r, q_r[PB-1]};
    ge    = trial >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      den_r  <= (den_w < WB'(1)) ? DB'(1) : den_w[DB-1:0];
      diff_r <= FB'(pk_c_r) - FB'(pk_a_r);
    end
    if (cmd.mul_load) begin
      rem_r <= n_w[PB+VB-1:PB];
      q_r   <= n_w[PB-1:0];
      d_r   <= {den_r, 2'b00};
    end else if (cmd.div_step) begin
      rem_r <= ge ? VB'(trial - {1'b0, d_r}) : trial[VB-1:0];
      q_r   <= {q_r[PB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.mul_load) begin
      step_r <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + psr_pkg::StepBits'(1);
    end
  end

  // result register
  logic                 out_valid_r;
  logic                 found_r;
  logic [IB-1:0]        idx_out_r;
  logic signed [SB-1:0] val_out_r, rv_out_r;
  logic [PB-1:0]        pos_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found_r   <= pk_ok_r;
      idx_out_r <= pk_ok_r ? pk_i_r : '0;
      val_out_r <= pk_ok_r ? pk_b_r : '0;
      pos_out_r <= pk_ok_r ? q_r : '0;
      rv_out_r  <= pk_ok_r ? sum_w[SB+1:2] : '0;
    end
  end

  assign stat.div_last        = step_r == psr_pkg::LastStep;
  assign stat.out_full        = out_valid_r;
  assign out_valid            = out_valid_r;
  assign out_found            = found_r;
  assign out_peak_index       = idx_out_r;
  assign out_peak_value       = val_out_r;
  assign out_refined_position = pos_out_r;
  assign out_refined_value    = rv_out_r;

endmodule

@@ rtl/peak_search_parabolic_refine_top.sv @@
// ----------------------------------------------------------------------------
// peak_search_parabolic_refine_top
// Samples stream in at one per cycle. The frame-end sample closes the frame;
// the block then runs the refinement (forming the parabola divisor, the index
// multiply, the one bit per cycle restoring divider, then loading the result
// register) and takes no sample during that time. The result register holds
// a finished result while the next frame streams in; if it is still full
// when the next result is ready, the block waits for it to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module peak_search_parabolic_refine_top (
  input  logic                               clk,
  input  logic                               rst_n,
  psr_in_if.sink                             in_ch,
  psr_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [psr_pkg::CfgIdxBits-1:0]     cfg_index,
  input  logic [psr_pkg::CfgBits-1:0]        cfg_data
);

  psr_pkg::psr_cmd_t  cmd;
  psr_pkg::psr_stat_t stat;

  psr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_frame_end (in_ch.frame_end),
    .in_ready     (in_ch.ready),
    .out_ready    (out_ch.ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  psr_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_sample            (in_ch.sample),
    .in_frame_end         (in_ch.frame_end),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_ready            (out_ch.ready),
    .out_valid            (out_ch.valid),
    .out_found            (out_ch.found),
    .out_peak_index       (out_ch.peak_index),
    .out_peak_value       (out_ch.peak_value),
    .out_refined_position (out_ch.refined_position),
    .out_refined_value    (out_ch.refined_value)
  );

  // no sample taken while the refinement is running
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.prep || cmd.mul_load || cmd.div_step) |-> !in_ch.ready)
    else $error("sample request accepted during refinement");

  a_frame_end_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.frame_end) |=> !in_ch.ready)
    else $error("input still ready after frame end");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |->
      (out_ch.peak_index == '0 && out_ch.peak_value == '0 &&
       out_ch.refined_position == '0 && out_ch.refined_value == '0))
    else $error("not-found result carries nonzero fields");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!stat.out_full || out_ch.ready))
    else $error("result overwritten before it was taken");

endmodule

@@ bench/psr_peak_checker.sv @@
// ----------------------------------------------------------------------------
// psr_peak_checker
// Watches the sample, result and register ports of the peak search block,
// predicts the per-frame peak result from the accepted samples and compares
// every accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psr_peak_checker
  import psr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  psr_in_if                     in_ch,
  psr_out_if                    out_ch,
  input  logic                  cfg_we,
  input  logic [CfgIdxBits-1:0] cfg_index,
  input  logic [CfgBits-1:0]    cfg_data,
  output int                    fail_count
);

  typedef struct {
    logic                         found;
    logic        [IndexBits-1:0]  peak_index;
    logic signed [SampleBits-1:0] peak_value;
    logic        [PosBits-1:0]    refined_position;
    logic signed [SampleBits-1:0] refined_value;
  } peak_result_t;

  peak_result_t pending_peaks[$];

  logic [IndexBits-1:0]  win_lo, win_hi;
  logic [KindBits-1:0]   kind;

  logic [CountBits-1:0]  count;
  logic signed [SampleBits-1:0] prev1, prev2;
  logic signed [SampleBits-1:0] best_v, best_l, best_r;
  logic [IndexBits-1:0]  best_i;
  logic [1:0]            hits;
  logic [IndexBits-1:0]  hit_i;
  logic signed [SampleBits-1:0] hit_l, hit_c, hit_r;

  initial fail_count = 0;

  task automatic clear_frame();
    count  = '0;
    prev1  = '0;
    prev2  = '0;
    best_v = '0;
    best_l = '0;
    best_r = '0;
    best_i = '0;
    hits   = '0;
    hit_i  = '0;
    hit_l  = '0;
    hit_c  = '0;
    hit_r  = '0;
  endtask

  task automatic predict_sample(input logic signed [SampleBits-1:0] s, input logic last);
    int i, ctr, lo, hi;
    logic ok;
    logic [IndexBits-1:0] idx;
    longint a, b, c, den, dd, num, pos, sum;
    peak_result_t r;
    i  = int'(count);
    lo = int'(win_lo);
    hi = int'(win_hi);
    if (i >= 1) begin
      ctr = i - 1;
      if (ctr >= lo && ctr <= hi && (ctr == lo || prev1 > best_v)) begin
        best_v = prev1;
        best_l = prev2;
        best_r = s;
        best_i = IndexBits'(ctr);
      end
      if (ctr > lo && ctr < hi && prev2 < prev1 && s < prev1 && hits < 2'd2) begin
        hits = hits + 2'd1;
        if (hits == kind) begin
          hit_i = IndexBits'(ctr);
          hit_l = prev2;
          hit_c = prev1;
          hit_r = s;
        end
      end
    end
    if (!last) begin
      prev2 = prev1;
      prev1 = s;
      if (count != CountMax) count = count + 1'b1;
      return;
    end
    if (kind == KIND_GLOBAL) begin
      ok = (hi < i + 1) && (lo < hi);
      if (ok && hi == i && s > best_v) ok = 1'b0;
      if (ok && (best_i == win_lo || best_i == win_hi)) ok = 1'b0;
      idx = best_i;
      a = best_l;
      b = best_v;
      c = best_r;
    end else begin
      ok = (kind <= KIND_SECOND) && (hi + 1 < i + 1) && (hits >= kind);
      idx = hit_i;
      a = hit_l;
      b = hit_c;
      c = hit_r;
    end
    r.found            = 1'b0;
    r.peak_index       = '0;
    r.peak_value       = '0;
    r.refined_position = '0;
    r.refined_value    = '0;
    if (ok) begin
      den = 2 * b - a - c;
      if (den < 1) den = 1;
      dd  = 2 * den;
      num = longint'(idx) * (longint'(1) << FracBits) * dd + (c - a) * (longint'(1) << FracBits);
      pos = (2 * num + dd) / (2 * dd);
      sum = a + 2 * b + c;
      r.found            = 1'b1;
      r.peak_index       = idx;
      r.peak_value       = SampleBits'(b);
      r.refined_position = PosBits'(pos);
      r.refined_value    = SampleBits'((sum + 2) >>> 2);
    end
    pending_peaks.push_back(r);
    clear_frame();
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    peak_result_t want;
    if (!rst_n) begin
      win_lo = WindowStartReset;
      win_hi = WindowStopReset;
      kind   = PeakKindReset;
      clear_frame();
      pending_peaks.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_peaks.size() == 0) begin
          $error("peak result with no frame pending");
          fail_count++;
        end else begin
          want = pending_peaks.pop_front();
          check_field("found", 32'(want.found), 32'(out_ch.found));
          check_field("peak_index", 32'(want.peak_index), 32'(out_ch.peak_index));
          check_field("peak_value", 32'(want.peak_value), 32'(out_ch.peak_value));
          check_field("refined_position", 32'(want.refined_position),
                      32'(out_ch.refined_position));
          check_field("refined_value", 32'(want.refined_value), 32'(out_ch.refined_value));
        end
      end
      if (in_ch.valid && in_ch.ready) predict_sample(in_ch.sample, in_ch.frame_end);
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_START: win_lo = cfg_data[IndexBits-1:0];
          REG_WINDOW_STOP:  win_hi = cfg_data[IndexBits-1:0];
          REG_PEAK_KIND:    kind   = cfg_data[KindBits-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ bench/tb_peak_search_parabolic_refine_top.sv @@
// ----------------------------------------------------------------------------
// tb_peak_search_parabolic_refine_top
// Streams sample frames into the peak search block under a series of window
// and peak kind settings, with random gaps on the sample side and random
// stalls on the result side; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_peak_search_parabolic_refine_top;
  import psr_pkg::*;

  localparam logic [KindBits-1:0] KIND_FIRST  = 2'd1;
  localparam logic [KindBits-1:0] KIND_UNUSED = 2'd3;
  localparam int RefineCycles = 21;

  typedef enum int { MODE_WIDE, MODE_NARROW, MODE_RAILS, MODE_BUMP } sample_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [CfgBits-1:0]    cfg_data;
  int   fail_count;
  int   frames_sent = 0;
  int   results_taken = 0;
  bit   calm = 1'b0;
  bit   squeeze = 1'b0;

  psr_in_if  in_ch ();
  psr_out_if out_ch ();

  peak_search_parabolic_refine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  psr_peak_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb_peak_search_parabolic_refine_top failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, one long hold-off to back the block up
  initial begin : result_sink
    int  stall_left;
    int  g;
    bit  pressed;
    stall_left = 0;
    pressed = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_ch.valid && out_ch.ready) results_taken <= results_taken + 1;
      if (!pressed && squeeze) begin
        pressed = 1'b1;
        stall_left = 600;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (calm) begin
        out_ch.ready <= 1'b1;
      end else begin
        g = pick_gap();
        out_ch.ready <= (g == 0);
        if (g > 0) stall_left = g - 1;
      end
      @(posedge clk);
    end
  end

  task automatic put(input logic signed [SampleBits-1:0] s, input logic last);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.sample    <= s;
    in_ch.frame_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (last) frames_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgBits'(value);
    @(posedge clk);
  endtask

  task automatic set_config(input int lo, input int hi, input logic [KindBits-1:0] kind);
    write_reg(REG_WINDOW_START, lo);
    write_reg(REG_WINDOW_STOP, hi);
    write_reg(REG_PEAK_KIND, int'(kind));
    cfg_we <= 1'b0;
  endtask

  // drain all results, then let the refinement pipeline settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (results_taken != frames_sent) @(posedge clk);
    repeat (RefineCycles + 4) @(posedge clk);
  endtask

  task automatic send_listed(input int vals[$]);
    for (int k = 0; k < vals.size(); k++)
      put(SampleBits'(vals[k]), k == vals.size() - 1);
  endtask

  task automatic send_frame(input int len, input sample_mode_t mode, input int center);
    int v, slope, span;
    slope = $urandom_range(1, 3000);
    for (int j = 0; j < len; j++) begin
      case (mode)
        MODE_WIDE:   v = int'($signed(SampleBits'($urandom)));
        MODE_NARROW: v = int'($urandom_range(0, 6)) - 3;
        MODE_RAILS: begin
          case ($urandom_range(0, 3))
            0: v = -32768;
            1: v = 32767;
            2: v = -1;
            default: v = 0;
          endcase
        end
        default: begin
          span = (j > center) ? j - center : center - j;
          v = 32767 - span * slope - int'($urandom_range(0, slope / 2));
          if (v < -32768) v = -32768;
        end
      endcase
      put(SampleBits'(v), j == len - 1);
    end
  endtask

  initial begin : stimulus
    int items, lo, hi, nframes, len, r, center;
    logic [KindBits-1:0] kind;
    sample_mode_t mode;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.sample    <= '0;
    in_ch.frame_end <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window reaches past a short frame
    send_listed('{-32768, 32767, 0, -1});
    wait_idle();

    // global max: interior hit, max on the window start, last sample over the stop edge
    set_config(1, 3, KIND_GLOBAL);
    send_listed('{0, 5, 32767, 5, -32768});
    send_listed('{0, 9, 1, 2, 3});
    send_listed('{0, 1, 5, 9});
    wait_idle();

    // first and second local peak, then unused kind
    set_config(0, 4, KIND_FIRST);
    send_listed('{-32768, 32767, -32768, 32767, -32768, 0});
    wait_idle();
    set_config(0, 4, KIND_SECOND);
    send_listed('{-32768, 32767, -32768, 32767, -32768, 0});
    send_listed('{3, 3, 3, 3, 3, 3, 3});
    wait_idle();
    set_config(0, 4, KIND_UNUSED);
    send_listed('{-5, 7, -5, 7, -5, 7, 0});
    wait_idle();

    // empty window at the top of the range
    set_config(1023, 1023, KIND_GLOBAL);
    send_listed('{1, 4, 2});
    wait_idle();

    // result side held off while short frames keep coming
    set_config(0, 3, KIND_GLOBAL);
    squeeze <= 1'b1;
    for (int f = 0; f < 8; f++) send_frame(6, MODE_WIDE, 0);
    wait_idle();

    // wider window further up the index range
    set_config(180, 250, KIND_GLOBAL);
    send_frame(256, MODE_BUMP, 215);
    wait_idle();
    set_config(180, 250, KIND_SECOND);
    send_frame(256, MODE_WIDE, 0);
    wait_idle();

    items = 0;
    while (items < 650) begin
      lo = $urandom_range(0, 8);
      if ($urandom_range(0, 9) == 0) hi = $urandom_range(0, lo);
      else hi = lo + $urandom_range(2, 16);
      r = $urandom_range(0, 99);
      if (r < 30) kind = KIND_GLOBAL;
      else if (r < 60) kind = KIND_FIRST;
      else if (r < 92) kind = KIND_SECOND;
      else kind = KIND_UNUSED;
      set_config(lo, hi, kind);
      calm <= ($urandom_range(0, 4) == 0);
      nframes = $urandom_range(3, 8);
      for (int f = 0; f < nframes; f++) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, hi + 1);
        else len = hi + 2 + $urandom_range(0, 8);
        mode = sample_mode_t'($urandom_range(0, 3));
        center = (lo <= hi) ? $urandom_range(lo, hi) : lo;
        send_frame(len, mode, center);
        items += len;
      end
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("tb_peak_search_parabolic_refine_top passed");
    end else begin
      $display("tb_peak_search_parabolic_refine_top failed");
    end
    $finish;
  end

endmodule

@@ peak_search_parabolic_refine_top.f @@
rtl/psr_pkg.sv
rtl/psr_if.sv
rtl/psr_ctrl.sv
rtl/psr_datapath.sv
rtl/peak_search_parabolic_refine_top.sv
bench/psr_peak_checker.sv
bench/tb_peak_search_parabolic_refine_top.sv
